>>> hdl/sre_pkg.sv
// ----------------------------------------------------------------------------
// sre_pkg
// Types, constants and helpers shared by the SEI record extractor.
// ----------------------------------------------------------------------------
package sre_pkg;

  localparam int unsigned MID_DEPTH_DEF = 2;
  localparam int unsigned OUT_DEPTH_DEF = 2;

  localparam logic [4:0] SEI_TYPE_H264     = 5'd6;
  localparam logic [5:0] SEI_TYPE_HEVC     = 6'd39;
  localparam logic [7:0] PAYLOAD_TYPE_USER = 8'd5;
  localparam logic [7:0] MIN_PAYLOAD       = 8'd39;
  localparam logic [7:0] EPB_BYTE          = 8'h03;
  localparam logic [7:0] RECORD_VERSION    = 8'd1;

  localparam logic [8:0] BODY_MAX    = 9'd511;
  localparam logic [8:0] OFF_MAGIC   = 9'd16;
  localparam logic [8:0] OFF_VERSION = 9'd20;
  localparam logic [8:0] OFF_EPOCH   = 9'd21;
  localparam logic [8:0] OFF_SEQ     = 9'd23;
  localparam logic [8:0] OFF_TIME    = 9'd27;
  localparam logic [8:0] OFF_SENSOR  = 9'd35;
  localparam logic [8:0] OFF_FLAGS   = 9'd37;
  localparam logic [8:0] OFF_END     = 9'd39;

  // classified item handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       body;
    logic       reject;
    logic       hdr_done;
  } front_item_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] epoch;
    logic [31:0] sequence_no;
    logic [63:0] time_ns;
    logic [15:0] sensor;
    logic [15:0] flags;
  } record_t;

  function automatic logic [7:0] uuid_byte(input logic [3:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = 8'h6a;
      4'd1:    b = 8'h8f;
      4'd2:    b = 8'h2b;
      4'd3:    b = 8'h4e;
      4'd4:    b = 8'h5d;
      4'd5:    b = 8'h3c;
      4'd6:    b = 8'h4a;
      4'd7:    b = 8'h1b;
      4'd8:    b = 8'h9e;
      4'd9:    b = 8'h7f;
      4'd10:   b = 8'h0c;
      4'd11:   b = 8'h2d;
      4'd12:   b = 8'h4b;
      4'd13:   b = 8'h6a;
      4'd14:   b = 8'h8e;
      default: b = 8'h10;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = 8'h43;
      2'd1:    b = 8'h53;
      2'd2:    b = 8'h59;
      default: b = 8'h4e;
    endcase
    return b;
  endfunction

endpackage

>>> hdl/sre_fifo.sv
// ----------------------------------------------------------------------------
// sre_fifo
// Small register-based queue, first word fall-through.
// ----------------------------------------------------------------------------
module sre_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> hdl/sre_front.sv
// ----------------------------------------------------------------------------
// sre_front
// Header check and emulation prevention removal; classifies each byte.
// ----------------------------------------------------------------------------
module sre_front
  import sre_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        codec_select_i,
  input  logic        accept_i,
  input  logic [7:0]  nal_byte_i,
  input  logic        is_last_i,
  output front_item_t item_o
);

  logic [1:0] raw_index_q, raw_index_d;
  logic [1:0] zero_run_q, zero_run_d;
  logic [1:0] hdr_len;
  logic       in_hdr;

  assign hdr_len = codec_select_i ? 2'd2 : 2'd1;
  assign in_hdr  = (raw_index_q < hdr_len);

  always_comb begin
    raw_index_d     = raw_index_q;
    zero_run_d      = zero_run_q;
    item_o.data     = nal_byte_i;
    item_o.last     = is_last_i;
    item_o.body     = 1'b0;
    item_o.reject   = 1'b0;
    if (in_hdr) begin
      if (raw_index_q == 2'd0) begin
        if (codec_select_i) begin
          item_o.reject = (nal_byte_i[6:1] != SEI_TYPE_HEVC);
        end else begin
          item_o.reject = (nal_byte_i[4:0] != SEI_TYPE_H264);
        end
      end
      raw_index_d = raw_index_q + 2'd1;
    end else if (zero_run_q == 2'd2 && nal_byte_i == EPB_BYTE) begin
      zero_run_d = 2'd0;
    end else begin
      item_o.body = 1'b1;
      if (nal_byte_i == 8'd0) begin
        if (zero_run_q != 2'd2) begin
          zero_run_d = zero_run_q + 2'd1;
        end
      end else begin
        zero_run_d = 2'd0;
      end
    end
    item_o.hdr_done = (raw_index_d >= hdr_len);
    if (is_last_i) begin
      raw_index_d = 2'd0;
      zero_run_d  = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_index_q <= 2'd0;
      zero_run_q  <= 2'd0;
    end else if (accept_i) begin
      raw_index_q <= raw_index_d;
      zero_run_q  <= zero_run_d;
    end
  end

endmodule

>>> hdl/sre_back.sv
// ----------------------------------------------------------------------------
// sre_back
// Payload parser: type, size, UUID, magic and version checks, field capture.
// ----------------------------------------------------------------------------
module sre_back
  import sre_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  input  front_item_t item_i,
  output logic        item_pop_o,
  input  logic        out_full_i,
  output logic        out_push_o,
  output record_t     record_o
);

  logic [8:0]  body_index_q, body_index_d;
  logic [7:0]  size_q, size_d;
  logic        reject_q, reject_d;
  logic [15:0] epoch_q, epoch_d;
  logic [31:0] seq_q, seq_d;
  logic [63:0] time_q, time_d;
  logic [15:0] sensor_q, sensor_d;
  logic [15:0] flags_q, flags_d;
  logic [8:0]  off;
  logic [7:0]  b;
  logic        ok;

  assign item_pop_o = item_valid_i && (!item_i.last || !out_full_i);
  assign out_push_o = item_pop_o && item_i.last;
  assign off        = body_index_q - 9'd2;
  assign b          = item_i.data;

  always_comb begin
    body_index_d = body_index_q;
    size_d       = size_q;
    reject_d     = reject_q | item_i.reject;
    epoch_d      = epoch_q;
    seq_d        = seq_q;
    time_d       = time_q;
    sensor_d     = sensor_q;
    flags_d      = flags_q;
    if (item_i.body) begin
      if (!reject_q) begin
        if (body_index_q == 9'd0) begin
          if (b != PAYLOAD_TYPE_USER) reject_d = 1'b1;
        end else if (body_index_q == 9'd1) begin
          size_d = b;
          if (b < MIN_PAYLOAD) reject_d = 1'b1;
        end else if (off < {1'b0, size_q}) begin
          priority if (off < OFF_MAGIC) begin
            if (b != uuid_byte(off[3:0])) reject_d = 1'b1;
          end else if (off < OFF_VERSION) begin
            if (b != magic_byte(off[1:0])) reject_d = 1'b1;
          end else if (off == OFF_VERSION) begin
            if (b != RECORD_VERSION) reject_d = 1'b1;
          end else if (off < OFF_SEQ) begin
            epoch_d = {epoch_q[7:0], b};
          end else if (off < OFF_TIME) begin
            seq_d = {seq_q[23:0], b};
          end else if (off < OFF_SENSOR) begin
            time_d = {time_q[55:0], b};
          end else if (off < OFF_FLAGS) begin
            sensor_d = {sensor_q[7:0], b};
          end else if (off < OFF_END) begin
            flags_d = {flags_q[7:0], b};
          end else begin
            reject_d = reject_q;
          end
        end
      end
      if (body_index_q != BODY_MAX) begin
        body_index_d = body_index_q + 9'd1;
      end
    end

    ok = !reject_d && item_i.hdr_done && (body_index_d >= 9'd2) &&
         (body_index_d >= (9'd2 + {1'b0, size_d}));
    record_o.valid       = ok;
    record_o.epoch       = ok ? epoch_d  : '0;
    record_o.sequence_no = ok ? seq_d    : '0;
    record_o.time_ns     = ok ? time_d   : '0;
    record_o.sensor      = ok ? sensor_d : '0;
    record_o.flags       = ok ? flags_d  : '0;

    if (item_i.last) begin
      body_index_d = '0;
      size_d       = '0;
      reject_d     = 1'b0;
      epoch_d      = '0;
      seq_d        = '0;
      time_d       = '0;
      sensor_d     = '0;
      flags_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      body_index_q <= '0;
      size_q       <= '0;
      reject_q     <= 1'b0;
      epoch_q      <= '0;
      seq_q        <= '0;
      time_q       <= '0;
      sensor_q     <= '0;
      flags_q      <= '0;
    end else if (item_pop_o) begin
      body_index_q <= body_index_d;
      size_q       <= size_d;
      reject_q     <= reject_d;
      epoch_q      <= epoch_d;
      seq_q        <= seq_d;
      time_q       <= time_d;
      sensor_q     <= sensor_d;
      flags_q      <= flags_d;
    end
  end

endmodule

>>> hdl/sei_record_extractor.sv
// ----------------------------------------------------------------------------
// sei_record_extractor
// Extracts the timing record from an SEI user-data-unregistered NAL unit.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the result queue is not full.
// Path: a last byte's result is registered in the byte queue, then in the
// result queue, before it is on the output; it is held back while the result
// queue is full.
// Reset: asynchronous, active low; clears both queues, the parser state and
// codec_select (H.264).
module sei_record_extractor
  import sre_pkg::*;
#(
  parameter int unsigned MID_DEPTH = MID_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        codec_select_we_i,
  input  logic        codec_select_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  nal_byte_i,
  input  logic        is_last_i,
  output logic        empty,
  input  logic        pop,
  output logic        record_valid_o,
  output logic [15:0] record_epoch_o,
  output logic [31:0] record_sequence_o,
  output logic [63:0] frame_time_ns_o,
  output logic [15:0] sensor_total_o,
  output logic [15:0] record_flag_bits_o
);

  logic        codec_q;
  logic        in_accept;
  front_item_t front_item, mid_item;
  logic        mid_empty, mid_pop;
  logic        out_push, out_full;
  record_t     back_rec, out_rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_q <= 1'b0;
    end else if (codec_select_we_i) begin
      codec_q <= codec_select_i;
    end
  end

  assign in_accept = push && !full;

  sre_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .codec_select_i (codec_q),
    .accept_i       (in_accept),
    .nal_byte_i     (nal_byte_i),
    .is_last_i      (is_last_i),
    .item_o         (front_item)
  );

  sre_fifo #(
    .WIDTH ($bits(front_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .full_o  (full),
    .pop_i   (mid_pop),
    .data_o  (mid_item),
    .empty_o (mid_empty)
  );

  sre_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (!mid_empty),
    .item_i       (mid_item),
    .item_pop_o   (mid_pop),
    .out_full_i   (out_full),
    .out_push_o   (out_push),
    .record_o     (back_rec)
  );

  sre_fifo #(
    .WIDTH ($bits(record_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (back_rec),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_rec),
    .empty_o (empty)
  );

  assign record_valid_o     = out_rec.valid;
  assign record_epoch_o     = out_rec.epoch;
  assign record_sequence_o  = out_rec.sequence_no;
  assign frame_time_ns_o    = out_rec.time_ns;
  assign sensor_total_o     = out_rec.sensor;
  assign record_flag_bits_o = out_rec.flags;

  a_no_result_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> !out_full)
    else $error("result pushed into a full queue");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mid_pop && mid_item.last) |-> out_push)
    else $error("last item consumed without a result");

  a_invalid_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !record_valid_o) |-> (record_epoch_o == '0 &&
      record_sequence_o == '0 && frame_time_ns_o == '0 &&
      sensor_total_o == '0 && record_flag_bits_o == '0))
    else $error("invalid record carries non-zero fields");

endmodule

>>> sim/sei_record_extractor_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sei_record_extractor_test
// Self-checking bench for the SEI record extractor. NAL units, well formed
// and broken, are built as escaped byte streams and queued for a clocked
// driver. A parser model in the bench predicts one record per NAL unit.
// A clocked monitor pops records at random and checks them field by field.
// ----------------------------------------------------------------------------
module sei_record_extractor_test;
  import sre_pkg::*;

  localparam logic [127:0] UUID_BYTES  = 128'h6a8f2b4e5d3c4a1b9e7f0c2d4b6a8e10;
  localparam logic [31:0]  MAGIC_BYTES = 32'h4353594e;

  typedef enum int {
    FLAW_NONE,
    FLAW_NAL_TYPE,
    FLAW_PAYLOAD_TYPE,
    FLAW_SHORT_SIZE,
    FLAW_UUID,
    FLAW_MAGIC,
    FLAW_VERSION,
    FLAW_TRUNCATED,
    FLAW_HDR_ONLY,
    FLAW_RAW_ZEROS,
    FLAW_NOISE
  } flaw_e;

  typedef enum int {
    FILL_MIXED,
    FILL_ZERO,
    FILL_ONES
  } fill_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } nal_byte_t;

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        codec_select_we_i = 1'b0;
  logic        codec_select_i    = 1'b0;
  logic        push              = 1'b0;
  logic        full;
  logic [7:0]  nal_byte_i        = 8'h00;
  logic        is_last_i         = 1'b0;
  logic        empty;
  logic        pop               = 1'b0;
  logic        record_valid_o;
  logic [15:0] record_epoch_o;
  logic [31:0] record_sequence_o;
  logic [63:0] frame_time_ns_o;
  logic [15:0] sensor_total_o;
  logic [15:0] record_flag_bits_o;

  nal_byte_t nal_bytes[$];
  record_t   expected_records[$];
  int        error_count  = 0;
  int        queued_bytes = 0;
  logic      no_gaps      = 1'b0;

  // parser model state
  logic        codec_cfg = 1'b0;
  logic [1:0]  hdr_seen;
  logic [1:0]  zero_cnt;
  logic [8:0]  body_cnt;
  logic [7:0]  payload_len;
  logic        rejected;
  logic [15:0] epoch_acc;
  logic [31:0] seq_acc;
  logic [63:0] time_acc;
  logic [15:0] sensor_acc;
  logic [15:0] flag_acc;

  sei_record_extractor i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .codec_select_we_i (codec_select_we_i),
    .codec_select_i    (codec_select_i),
    .push              (push),
    .full              (full),
    .nal_byte_i        (nal_byte_i),
    .is_last_i         (is_last_i),
    .empty             (empty),
    .pop               (pop),
    .record_valid_o    (record_valid_o),
    .record_epoch_o    (record_epoch_o),
    .record_sequence_o (record_sequence_o),
    .frame_time_ns_o   (frame_time_ns_o),
    .sensor_total_o    (sensor_total_o),
    .record_flag_bits_o(record_flag_bits_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic clear_parse();
    hdr_seen    = '0;
    zero_cnt    = '0;
    body_cnt    = '0;
    payload_len = '0;
    rejected    = 1'b0;
    epoch_acc   = '0;
    seq_acc     = '0;
    time_acc    = '0;
    sensor_acc  = '0;
    flag_acc    = '0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last);
    int      hdr_len;
    int      off;
    logic    ok;
    record_t rec;
    hdr_len = codec_cfg ? 2 : 1;
    if (int'(hdr_seen) < hdr_len) begin
      if (hdr_seen == 2'd0) begin
        if (codec_cfg) begin
          if (b[6:1] != SEI_TYPE_HEVC) rejected = 1'b1;
        end else if (b[4:0] != SEI_TYPE_H264) begin
          rejected = 1'b1;
        end
      end
      hdr_seen = hdr_seen + 2'd1;
    end else if (zero_cnt >= 2'd2 && b == EPB_BYTE) begin
      zero_cnt = '0;
    end else begin
      if (!rejected) begin
        off = int'(body_cnt) - 2;
        if (body_cnt == 9'd0) begin
          if (b != PAYLOAD_TYPE_USER) rejected = 1'b1;
        end else if (body_cnt == 9'd1) begin
          payload_len = b;
          if (b < MIN_PAYLOAD) rejected = 1'b1;
        end else if (off < int'(payload_len)) begin
          if (off < 16) begin
            if (b != UUID_BYTES[127 - 8*off -: 8]) rejected = 1'b1;
          end else if (off < 20) begin
            if (b != MAGIC_BYTES[31 - 8*(off - 16) -: 8]) rejected = 1'b1;
          end else if (off == 20) begin
            if (b != RECORD_VERSION) rejected = 1'b1;
          end else if (off < 23) begin
            epoch_acc = {epoch_acc[7:0], b};
          end else if (off < 27) begin
            seq_acc = {seq_acc[23:0], b};
          end else if (off < 35) begin
            time_acc = {time_acc[55:0], b};
          end else if (off < 37) begin
            sensor_acc = {sensor_acc[7:0], b};
          end else if (off < 39) begin
            flag_acc = {flag_acc[7:0], b};
          end
        end
      end
      if (body_cnt < BODY_MAX) body_cnt = body_cnt + 9'd1;
      if (b != 8'd0) zero_cnt = '0;
      else if (zero_cnt < 2'd2) zero_cnt = zero_cnt + 2'd1;
    end
    if (last) begin
      ok = !rejected && int'(hdr_seen) >= hdr_len && body_cnt >= 9'd2 &&
           int'(body_cnt) >= 2 + int'(payload_len);
      rec = '0;
      if (ok) begin
        rec.valid       = 1'b1;
        rec.epoch       = epoch_acc;
        rec.sequence_no = seq_acc;
        rec.time_ns     = time_acc;
        rec.sensor      = sensor_acc;
        rec.flags       = flag_acc;
      end
      expected_records.insert(expected_records.size(), rec);
      clear_parse();
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        parse_byte(nal_byte_i, is_last_i);
        void'(nal_bytes.pop_front());
      end
      if (!(push && full)) begin
        if (nal_bytes.size() != 0 && (no_gaps || $urandom_range(99) >= 9)) begin
          push       <= 1'b1;
          nal_byte_i <= nal_bytes[0].data;
          is_last_i  <= nal_bytes[0].last;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    record_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_records.size() == 0) begin
          $error("record with no item waiting for it");
          error_count++;
        end else begin
          want = expected_records.pop_front();
          check_field("record_valid", 64'(want.valid), 64'(record_valid_o));
          check_field("record_epoch", 64'(want.epoch), 64'(record_epoch_o));
          check_field("record_sequence", 64'(want.sequence_no), 64'(record_sequence_o));
          check_field("frame_time_ns", want.time_ns, frame_time_ns_o);
          check_field("sensor_total", 64'(want.sensor), 64'(sensor_total_o));
          check_field("record_flag_bits", 64'(want.flags), 64'(record_flag_bits_o));
        end
      end
      pop <= no_gaps || ($urandom_range(99) >= 9);
    end
  end

  function automatic logic [7:0] fill_byte(input fill_e fill);
    int r;
    r = $urandom_range(99);
    case (fill)
      FILL_ZERO: return 8'h00;
      FILL_ONES: return 8'hff;
      default: begin
        if (r < 25) return 8'h00;
        if (r < 35) return 8'($urandom_range(3));
        return 8'($urandom_range(255));
      end
    endcase
  endfunction

  task automatic queue_nal(input flaw_e flaw, input int psize, input int tail,
                           input fill_e fill);
    logic [7:0] body[$];
    logic [7:0] raw[$];
    logic [7:0] b;
    nal_byte_t  nb;
    int         sz;
    int         bad_pos;
    int         cut;
    int         zc;
    sz = (flaw == FLAW_SHORT_SIZE) ? $urandom_range(38) : psize;
    bad_pos = -1;
    if (flaw == FLAW_UUID) bad_pos = $urandom_range(15);
    if (flaw == FLAW_MAGIC) bad_pos = $urandom_range(19, 16);
    if (flaw == FLAW_NOISE) begin
      repeat ($urandom_range(60, 1)) raw.insert(raw.size(), 8'($urandom_range(255)));
    end else begin
      if (codec_cfg) begin
        b = {1'($urandom_range(1)), SEI_TYPE_HEVC, 1'($urandom_range(1))};
        if (flaw == FLAW_NAL_TYPE) b[6:1] = 6'((39 + $urandom_range(63, 1)) % 64);
        raw.insert(raw.size(), b);
        if (flaw != FLAW_HDR_ONLY) raw.insert(raw.size(), 8'($urandom_range(255)));
      end else begin
        b = {3'($urandom_range(7)), SEI_TYPE_H264};
        if (flaw == FLAW_NAL_TYPE) b[4:0] = 5'((6 + $urandom_range(31, 1)) % 32);
        raw.insert(raw.size(), b);
      end
      if (flaw != FLAW_HDR_ONLY) begin
        if (flaw == FLAW_PAYLOAD_TYPE) begin
          body.insert(body.size(), 8'((5 + $urandom_range(255, 1)) % 256));
        end else begin
          body.insert(body.size(), PAYLOAD_TYPE_USER);
        end
        body.insert(body.size(), 8'(sz));
        for (int off = 0; off < sz; off++) begin
          if (off < 16) b = UUID_BYTES[127 - 8*off -: 8];
          else if (off < 20) b = MAGIC_BYTES[31 - 8*(off - 16) -: 8];
          else if (off == 20) b = RECORD_VERSION;
          else b = fill_byte(fill);
          if (off == bad_pos) b = b ^ 8'($urandom_range(255, 1));
          if (off == 20 && flaw == FLAW_VERSION) begin
            b = 8'($urandom_range(255));
            if (b == RECORD_VERSION) b = 8'h00;
          end
          body.insert(body.size(), b);
        end
        repeat (tail) body.insert(body.size(), fill_byte(FILL_MIXED));
        if (flaw == FLAW_TRUNCATED) begin
          cut = $urandom_range(sz + 1);
          while (body.size() > cut) void'(body.pop_back());
        end
        // escape the body; the odd spare escape is dropped by the parser too
        zc = 0;
        foreach (body[i]) begin
          if (flaw != FLAW_RAW_ZEROS && zc >= 2 &&
              (body[i] <= EPB_BYTE || $urandom_range(19) == 0)) begin
            raw.insert(raw.size(), EPB_BYTE);
            zc = 0;
          end
          raw.insert(raw.size(), body[i]);
          zc = (body[i] == 8'h00) ? zc + 1 : 0;
        end
      end
    end
    foreach (raw[i]) begin
      nb.data = raw[i];
      nb.last = (i == raw.size() - 1);
      nal_bytes.insert(nal_bytes.size(), nb);
    end
    queued_bytes += raw.size();
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (nal_bytes.size() != 0 || push || expected_records.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_codec(input logic value);
    @(posedge clk_i);
    codec_select_we_i <= 1'b1;
    codec_select_i    <= value;
    @(posedge clk_i);
    codec_select_we_i <= 1'b0;
    codec_cfg = value;
  endtask

  task automatic run_random(input int byte_goal, input int nal_goal);
    int    start;
    int    nals;
    int    r;
    int    psize;
    int    tail;
    flaw_e flaw;
    start = queued_bytes;
    nals  = 0;
    while (queued_bytes - start < byte_goal || nals < nal_goal) begin
      r = $urandom_range(99);
      flaw = (r < 65) ? FLAW_NONE : flaw_e'($urandom_range(FLAW_NOISE, FLAW_NAL_TYPE));
      psize = ($urandom_range(99) < 88) ? 39 + $urandom_range(20) : $urandom_range(255, 39);
      tail = $urandom_range(4);
      queue_nal(flaw, psize, tail, FILL_MIXED);
      nals++;
    end
    drain();
  endtask

  initial begin
    clear_parse();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // H.264 at the reset setting
    queue_nal(FLAW_NONE, 39, 0, FILL_MIXED);
    queue_nal(FLAW_NONE, 39, 2, FILL_ZERO);
    queue_nal(FLAW_NONE, 39, 1, FILL_ONES);
    queue_nal(FLAW_NONE, 38, 0, FILL_MIXED);
    // largest payload with a body long enough to saturate the counter
    queue_nal(FLAW_NONE, 255, 260, FILL_MIXED);
    for (int f = FLAW_NAL_TYPE; f <= FLAW_NOISE; f++) begin
      queue_nal(flaw_e'(f), 39, 0, FILL_MIXED);
    end
    drain();

    write_codec(1'b1);
    queue_nal(FLAW_NONE, 39, 0, FILL_MIXED);
    queue_nal(FLAW_NONE, 39, 3, FILL_ZERO);
    queue_nal(FLAW_HDR_ONLY, 39, 0, FILL_MIXED);
    queue_nal(FLAW_NAL_TYPE, 39, 0, FILL_MIXED);
    queue_nal(FLAW_TRUNCATED, 50, 0, FILL_MIXED);
    queue_nal(FLAW_NONE, 80, 0, FILL_ONES);
    drain();

    run_random(40, 1);
    write_codec(1'b0);
    run_random(40, 1);
    write_codec(1'b1);
    no_gaps = 1'b1;
    run_random(120, 1);
    no_gaps = 1'b0;
    write_codec(1'b0);
    run_random(40, 1);

    if (error_count == 0) begin
      $display("PASS sei_record_extractor");
    end else begin
      $display("FAIL sei_record_extractor");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL sei_record_extractor");
    $finish;
  end

endmodule
